// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- sv/tlcd_pkg.sv -----
`timescale 1ns / 1ps

package tlcd_pkg;

   localparam logic [1:0] CMD_CHAR     = 2'd0;
   localparam logic [1:0] CMD_NUMBER   = 2'd1;
   localparam logic [1:0] CMD_POSITION = 2'd2;

   localparam logic [7:0] PAGE_BASE    = 8'hB0;
   localparam logic [7:0] COL_HI_BASE  = 8'h10;
   localparam logic [7:0] BLANK_COLUMN = 8'h00;
   localparam logic [7:0] ZERO_CHAR    = 8'h30;
   localparam logic [7:0] FONT_FIRST   = 8'h20;
   localparam int         FONT_COUNT   = 96;

   typedef logic [0:4][7:0] glyph_type;

   typedef struct packed {
      logic load;
      logic sub;
      logic set_code;
      logic emit;
      logic last;
      logic pos_mode;
      logic next_digit;
   } tlcd_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic ge;
      logic col_is2;
      logic col_is5;
      logic digit_last;
   } tlcd_status_type;

   localparam glyph_type FONT [FONT_COUNT] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h007f3e1c08
   };

   function automatic logic [13:0] dec_weight(input logic [1:0] idx);
      logic [13:0] w;
      case (idx)
         2'd0:    w = 14'd10000;
         2'd1:    w = 14'd1000;
         2'd2:    w = 14'd100;
         default: w = 14'd10;
      endcase
      return w;
   endfunction

endpackage

// ----- sv/tlcd_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlcd_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                char_code,
   input  logic [15:0]               number,
   input  logic [6:0]                column_x,
   input  logic [3:0]                page_y,
   input  tlcd_pkg::tlcd_cmd_type    cmd_i,
   output tlcd_pkg::tlcd_status_type status_o,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   logic [7:0]  code_ff,  code_in;
   logic [15:0] value_ff, value_in;
   logic [3:0]  digit_ff, digit_in;
   logic [2:0]  widx_ff,  widx_in;
   logic [2:0]  col_ff,   col_in;
   logic [6:0]  x_ff,     x_in;
   logic [3:0]  y_ff,     y_in;
   logic [7:0]  byte_ff,  byte_in;
   logic        user_ff,  user_in;
   logic        last_ff,  last_in;
   logic        valid_ff, valid_in;

   logic [15:0] weight;
   logic        in_font;
   logic [6:0]  font_idx;
   logic [2:0]  glyph_col;
   logic [7:0]  glyph_byte;
   logic [7:0]  pos_byte;
   logic [3:0]  digit_val;

   assign weight     = {2'b00, tlcd_pkg::dec_weight(widx_ff[1:0])};
   assign in_font    = !code_ff[7] && (code_ff[6:5] != 2'b00);
   assign font_idx   = code_ff[6:0] - tlcd_pkg::FONT_FIRST[6:0];
   assign glyph_col  = col_ff - 3'd1;
   assign digit_val  = widx_ff[2] ? value_ff[3:0] : digit_ff;

   always_comb begin
      if (col_ff == 3'd0 || !in_font) begin
         glyph_byte = tlcd_pkg::BLANK_COLUMN;
      end else begin
         glyph_byte = tlcd_pkg::FONT[font_idx][glyph_col];
      end
      case (col_ff)
         3'd0:    pos_byte = tlcd_pkg::PAGE_BASE | {4'h0, y_ff};
         3'd1:    pos_byte = tlcd_pkg::COL_HI_BASE | {5'b00000, x_ff[6:4]};
         default: pos_byte = {4'h0, x_ff[3:0]};
      endcase
   end

   always_comb begin
      code_in  = code_ff;
      value_in = value_ff;
      digit_in = digit_ff;
      widx_in  = widx_ff;
      col_in   = col_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      byte_in  = byte_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (cmd_i.load) begin
         code_in  = char_code;
         value_in = number;
         x_in     = column_x;
         y_in     = page_y;
         digit_in = 4'd0;
         widx_in  = 3'd0;
         col_in   = 3'd0;
      end
      if (cmd_i.sub) begin
         value_in = value_ff - weight;
         digit_in = digit_ff + 4'd1;
      end
      if (cmd_i.set_code) begin
         code_in = tlcd_pkg::ZERO_CHAR + {4'h0, digit_val};
         col_in  = 3'd0;
      end
      if (cmd_i.emit) begin
         byte_in  = cmd_i.pos_mode ? pos_byte : glyph_byte;
         user_in  = !cmd_i.pos_mode;
         last_in  = cmd_i.last;
         valid_in = 1'b1;
         col_in   = col_ff + 3'd1;
      end
      if (cmd_i.next_digit) begin
         widx_in  = widx_ff + 3'd1;
         digit_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff  <= code_in;
      value_ff <= value_in;
      digit_ff <= digit_in;
      widx_ff  <= widx_in;
      col_ff   <= col_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      byte_ff  <= byte_in;
      user_ff  <= user_in;
      last_ff  <= last_in;
   end

   assign status_o.slot_free  = !valid_ff || rsp_tready;
   assign status_o.ge         = !widx_ff[2] && (value_ff >= weight);
   assign status_o.col_is2    = (col_ff == 3'd2);
   assign status_o.col_is5    = (col_ff == 3'd5);
   assign status_o.digit_last = widx_ff[2];

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   `ASSERT_IMPLIES(a_emit_slot, clock, reset, cmd_i.emit, !valid_ff || rsp_tready)
   `ASSERT_IMPLIES(a_digit_range, clock, reset, cmd_i.set_code, digit_val <= 4'd9)

endmodule

// ----- sv/tlcd_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlcd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [1:0]                req_cmd,
   input  tlcd_pkg::tlcd_status_type status_i,
   output tlcd_pkg::tlcd_cmd_type    cmd_o
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CHAR = 4'b0010,
      ST_SUB  = 4'b0100,
      ST_POS  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      num_mode_ff, num_mode_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      num_mode_in = num_mode_ff;
      cmd_o       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_o.load = 1'b1;
               unique case (req_cmd)
                  tlcd_pkg::CMD_CHAR: begin
                     num_mode_in = 1'b0;
                     state_in    = ST_CHAR;
                  end
                  tlcd_pkg::CMD_NUMBER: begin
                     num_mode_in = 1'b1;
                     state_in    = ST_SUB;
                  end
                  tlcd_pkg::CMD_POSITION: begin
                     state_in = ST_POS;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SUB: begin
            if (status_i.ge) begin
               cmd_o.sub = 1'b1;
            end else begin
               cmd_o.set_code = 1'b1;
               state_in       = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (status_i.slot_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.last = status_i.col_is5 && (!num_mode_ff || status_i.digit_last);
               if (status_i.col_is5) begin
                  if (num_mode_ff && !status_i.digit_last) begin
                     cmd_o.next_digit = 1'b1;
                     state_in         = ST_SUB;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_POS: begin
            cmd_o.pos_mode = 1'b1;
            if (status_i.slot_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.last = status_i.col_is2;
               if (status_i.col_is2) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         num_mode_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         num_mode_ff <= num_mode_in;
      end
   end

   `ASSERT_NEXT(a_last_to_idle, clock, reset, cmd_o.emit && cmd_o.last, state_ff == ST_IDLE)
   `ASSERT_IMPLIES(a_emit_from_run, clock, reset, cmd_o.emit,
                   state_ff == ST_CHAR || state_ff == ST_POS)

endmodule

// ----- sv/text_to_lcd_column_bytes.sv -----
`timescale 1ns / 1ps
// Character generator for a page-addressed monochrome LCD, 5x8 font.
// Input channel req_*: one word per item; req_tuser selects the command
// (character, five-digit decimal number, cursor position).
// Output channel rsp_*: one display byte per word; rsp_tuser is high for a
// data byte and low for a controller command byte; rsp_tlast marks the
// final byte of the item's run. Command code 3 is taken and yields nothing.
// One item is in work at a time; req_tready is high only between items.
// A character is accepted, then sent as six column bytes (a blank column and
// five font columns); a position as three command bytes. A number is sent as
// five digit characters: each of the four upper digits is found by one
// subtract-and-compare per cycle, the last is the remainder, and each digit is
// rendered as six bytes, one per cycle through the output register unless the
// receiver stalls. After accept the sequencer state is registered, then the first byte.
// When the receiver stalls the output register holds its word and the
// sequencer waits; the next item may be accepted while the final byte of
// the previous run still waits. Reset empties the output register and
// returns the sequencer to idle.

module text_to_lcd_column_bytes (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // char_code, number, column_x, page_y, zero pad
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tuser,   // is_data
   output logic        rsp_tlast
);

   tlcd_pkg::tlcd_cmd_type    dp_cmd;
   tlcd_pkg::tlcd_status_type dp_status;

   tlcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .status_i   (dp_status),
      .cmd_o      (dp_cmd)
   );

   tlcd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .char_code  (req_tdata[7:0]),
      .number     (req_tdata[23:8]),
      .column_x   (req_tdata[30:24]),
      .page_y     (req_tdata[34:31]),
      .cmd_i      (dp_cmd),
      .status_o   (dp_status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [7:0] GLYPH_FIRST  = 8'h20;
   localparam logic [7:0] GLYPH_LAST   = 8'h7F;
   localparam int         DRAIN_CYCLES = 100;
   localparam int         CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic [7:0] col;
      logic       is_data;
      logic       last;
   } lcd_word_type;

   localparam logic [39:0] GLYPH_ROM [96] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h007f3e1c08
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // char_code, number, column_x, page_y, zero pad
   logic [1:0]  req_tuser  = tlcd_pkg::CMD_CHAR;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // out_byte
   logic        rsp_tuser;   // is_data
   logic        rsp_tlast;

   lcd_word_type pending_bytes [$];
   int           send_idle     = 0;
   int           recv_idle     = 0;
   int           errors        = 0;
   int           items_sent    = 0;
   int           words_checked = 0;
   int           cycles        = 0;

   text_to_lcd_column_bytes i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch %s: got %0h want %0h at word %0d", what, got, want, words_checked);
      errors++;
   endtask

   function automatic lcd_word_type make_word(input logic [7:0] col, input logic is_data,
                                              input logic last);
      lcd_word_type w;
      w.col     = col;
      w.is_data = is_data;
      w.last    = last;
      return w;
   endfunction

   task automatic add_glyph(input logic [7:0] code, input logic end_run);
      logic [39:0] g;
      g = (code >= GLYPH_FIRST && code <= GLYPH_LAST) ? GLYPH_ROM[code - GLYPH_FIRST] : '0;
      pending_bytes.push_back(make_word(tlcd_pkg::BLANK_COLUMN, 1'b1, 1'b0));
      for (int c = 0; c < 5; c++)
         pending_bytes.push_back(make_word(g[39 - 8 * c -: 8], 1'b1, end_run && (c == 4)));
   endtask

   task automatic predict_columns(input logic [1:0] cmd, input logic [39:0] d);
      logic [15:0] v;
      logic [6:0]  x;
      logic [3:0]  y;
      v = d[23:8];
      x = d[30:24];
      y = d[34:31];
      case (cmd)
         tlcd_pkg::CMD_CHAR: begin
            add_glyph(d[7:0], 1'b1);
         end
         tlcd_pkg::CMD_NUMBER: begin
            add_glyph(tlcd_pkg::ZERO_CHAR + 8'(v / 16'd10000), 1'b0);
            v = v % 16'd10000;
            add_glyph(tlcd_pkg::ZERO_CHAR + 8'(v / 16'd1000), 1'b0);
            v = v % 16'd1000;
            add_glyph(tlcd_pkg::ZERO_CHAR + 8'(v / 16'd100), 1'b0);
            v = v % 16'd100;
            add_glyph(tlcd_pkg::ZERO_CHAR + 8'(v / 16'd10), 1'b0);
            add_glyph(tlcd_pkg::ZERO_CHAR + 8'(v % 16'd10), 1'b1);
         end
         tlcd_pkg::CMD_POSITION: begin
            pending_bytes.push_back(make_word(tlcd_pkg::PAGE_BASE | {4'b0, y}, 1'b0, 1'b0));
            pending_bytes.push_back(make_word(tlcd_pkg::COL_HI_BASE | {5'b0, x[6:4]},
                                              1'b0, 1'b0));
            pending_bytes.push_back(make_word({4'b0, x[3:0]}, 1'b0, 1'b1));
         end
         default: begin
         end
      endcase
   endtask

   // predict on every accepted item
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         predict_columns(req_tuser, req_tdata);
   end

   always @(posedge clock) begin : check_words
      lcd_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 8'd0);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.col)
               report_mismatch("out_byte", rsp_tdata, want.col);
            if (rsp_tuser !== want.is_data)
               report_mismatch("is_data", {7'd0, rsp_tuser}, {7'd0, want.is_data});
            if (rsp_tlast !== want.last)
               report_mismatch("last", {7'd0, rsp_tlast}, {7'd0, want.last});
         end
         words_checked++;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // hold valid high across back-to-back words; drop it only for a gap
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] code,
                            input logic [15:0] num, input logic [6:0] x, input logic [3:0] y);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, y, x, num, code};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic test_characters;
      send_word(tlcd_pkg::CMD_CHAR, 8'h00, 16'hFFFF, 7'h7F, 4'hF);
      send_word(tlcd_pkg::CMD_CHAR, 8'h1F, 16'h0000, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_CHAR, 8'h20, 16'h0000, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_CHAR, 8'h7F, 16'h0000, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_CHAR, 8'h80, 16'h0000, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_CHAR, 8'hFF, 16'h0000, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_CHAR, 8'h41, 16'h0000, 7'h00, 4'h0);
   endtask

   task automatic test_numbers;
      send_word(tlcd_pkg::CMD_NUMBER, 8'hFF, 16'd0, 7'h7F, 4'hF);
      send_word(tlcd_pkg::CMD_NUMBER, 8'h00, 16'd65535, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_NUMBER, 8'h00, 16'd10000, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_NUMBER, 8'h00, 16'd9999, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_NUMBER, 8'h00, 16'd1, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_NUMBER, 8'h00, 16'd12345, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_NUMBER, 8'h00, 16'd60000, 7'h00, 4'h0);
   endtask

   task automatic test_positions;
      send_word(tlcd_pkg::CMD_POSITION, 8'hFF, 16'hFFFF, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_POSITION, 8'h00, 16'h0000, 7'h7F, 4'hF);
      send_word(tlcd_pkg::CMD_POSITION, 8'h00, 16'h0000, 7'h5A, 4'h6);
   endtask

   task automatic test_unused_cmd;
      send_word(CMD_UNUSED, 8'hFF, 16'hFFFF, 7'h7F, 4'hF);
      send_word(CMD_UNUSED, 8'h00, 16'h0000, 7'h00, 4'h0);
      send_word(tlcd_pkg::CMD_CHAR, 8'h7E, 16'h0000, 7'h00, 4'h0);
   endtask

   task automatic test_random_mix(input int n, input int s_idle, input int r_idle);
      int          pick;
      int          sel;
      logic [1:0]  cmd;
      logic [7:0]  code;
      logic [15:0] num;
      logic [6:0]  x;
      logic [3:0]  y;
      send_idle = s_idle;
      recv_idle = r_idle;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         code = 8'($urandom);
         num  = 16'($urandom);
         x    = 7'($urandom);
         y    = 4'($urandom);
         if (pick < 35) begin
            cmd = tlcd_pkg::CMD_CHAR;
            if ($urandom_range(0, 3) != 0)
               code = 8'($urandom_range(32, 127));
         end else if (pick < 65) begin
            cmd = tlcd_pkg::CMD_NUMBER;
            sel = $urandom_range(0, 7);
            if (sel == 0)
               num = 16'd0;
            else if (sel == 1)
               num = 16'hFFFF;
            else if (sel == 2)
               num = 16'($urandom_range(0, 99));
         end else if (pick < 92) begin
            cmd = tlcd_pkg::CMD_POSITION;
         end else begin
            cmd = CMD_UNUSED;
         end
         send_word(cmd, code, num, x, y);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_characters;
      test_numbers;
      test_positions;
      test_unused_cmd;
      test_random_mix(143, 34, 69);
      test_random_mix(143, 69, 34);
      test_random_mix(143, 0, 0);
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d items (characters, numbers, positions, unused codes)", items_sent);
      $display("checked %0d column and command words under three stall profiles",
               words_checked);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- text_to_lcd_column_bytes.f -----
+incdir+sv
sv/tlcd_pkg.sv
sv/tlcd_dp.sv
sv/tlcd_ctrl.sv
sv/text_to_lcd_column_bytes.sv
tb/tb_top.sv
